/* hw/rtl/wtss_pkg.sv */
// ----------------------------------------------------------------------------
// wtss_pkg: word table sort and search, shared definitions
// codes, microcode control word layout and the microcode program
// ----------------------------------------------------------------------------
package wtss_pkg;

   localparam int WORD_W  = 64;
   localparam int IDX_W   = 10;
   localparam int STATUS_W = 2;
   localparam int REQ_W   = 2;
   localparam int STEP_W  = 5;

   typedef enum logic [REQ_W-1:0] {
      REQ_APPEND = 2'd0,
      REQ_SORT   = 2'd1,
      REQ_SEARCH = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE      = 2'd0,
      STS_FOUND     = 2'd1,
      STS_NOT_FOUND = 2'd2,
      STS_FULL      = 2'd3
   } status_type;

   typedef enum logic [STEP_W-1:0] {
      STEP_IDLE     = 5'd0,
      STEP_DISPATCH = 5'd1,
      STEP_APP_CHK  = 5'd2,
      STEP_APP_WR   = 5'd3,
      STEP_FULL     = 5'd4,
      STEP_S_INIT   = 5'd5,
      STEP_S_OUTER  = 5'd6,
      STEP_S_LOAD   = 5'd7,
      STEP_S_RDJ    = 5'd8,
      STEP_S_CMP    = 5'd9,
      STEP_S_WRI    = 5'd10,
      STEP_S_WRB    = 5'd11,
      STEP_DONE     = 5'd12,
      STEP_R_INIT   = 5'd13,
      STEP_R_MID    = 5'd14,
      STEP_R_PROBE  = 5'd15,
      STEP_R_FOUND  = 5'd16,
      STEP_R_NFOUND = 5'd17
   } step_type;

   typedef enum logic [4:0] {
      ACT_NOP,
      ACT_LATCH,
      ACT_APPEND,
      ACT_EMIT_FULL,
      ACT_EMIT_DONE,
      ACT_SORT_INIT,
      ACT_OUTER,
      ACT_LOAD,
      ACT_READ_J,
      ACT_CMP,
      ACT_WRITE_I,
      ACT_WRITE_BEST,
      ACT_SRCH_INIT,
      ACT_MID,
      ACT_PROBE,
      ACT_EMIT_FOUND,
      ACT_EMIT_NFOUND
   } action_type;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_GOTO,
      JMP_IF,
      JMP_WAIT,
      JMP_DISPATCH
   } jump_type;

   typedef enum logic [2:0] {
      CND_NONE,
      CND_FULL,
      CND_LT2,
      CND_J_MORE,
      CND_I_MORE,
      CND_EMPTY_RANGE,
      CND_KEY_NE
   } cond_type;

   typedef struct packed {
      action_type action;
      jump_type   jump;
      cond_type   cond;
      step_type   target;
   } uword_type;

   function automatic uword_type ucode_rom(step_type s);
      uword_type w;
      unique case (s)
         STEP_IDLE:     w = '{ACT_LATCH,       JMP_WAIT,     CND_NONE,        STEP_DISPATCH};
         STEP_DISPATCH: w = '{ACT_NOP,         JMP_DISPATCH, CND_NONE,        STEP_IDLE};
         STEP_APP_CHK:  w = '{ACT_NOP,         JMP_IF,       CND_FULL,        STEP_FULL};
         STEP_APP_WR:   w = '{ACT_APPEND,      JMP_GOTO,     CND_NONE,        STEP_IDLE};
         STEP_FULL:     w = '{ACT_EMIT_FULL,   JMP_GOTO,     CND_NONE,        STEP_IDLE};
         STEP_S_INIT:   w = '{ACT_SORT_INIT,   JMP_IF,       CND_LT2,         STEP_DONE};
         STEP_S_OUTER:  w = '{ACT_OUTER,       JMP_NEXT,     CND_NONE,        STEP_IDLE};
         STEP_S_LOAD:   w = '{ACT_LOAD,        JMP_NEXT,     CND_NONE,        STEP_IDLE};
         STEP_S_RDJ:    w = '{ACT_READ_J,      JMP_NEXT,     CND_NONE,        STEP_IDLE};
         STEP_S_CMP:    w = '{ACT_CMP,         JMP_IF,       CND_J_MORE,      STEP_S_RDJ};
         STEP_S_WRI:    w = '{ACT_WRITE_I,     JMP_NEXT,     CND_NONE,        STEP_IDLE};
         STEP_S_WRB:    w = '{ACT_WRITE_BEST,  JMP_IF,       CND_I_MORE,      STEP_S_OUTER};
         STEP_DONE:     w = '{ACT_EMIT_DONE,   JMP_GOTO,     CND_NONE,        STEP_IDLE};
         STEP_R_INIT:   w = '{ACT_SRCH_INIT,   JMP_NEXT,     CND_NONE,        STEP_IDLE};
         STEP_R_MID:    w = '{ACT_MID,         JMP_IF,       CND_EMPTY_RANGE, STEP_R_NFOUND};
         STEP_R_PROBE:  w = '{ACT_PROBE,       JMP_IF,       CND_KEY_NE,      STEP_R_MID};
         STEP_R_FOUND:  w = '{ACT_EMIT_FOUND,  JMP_GOTO,     CND_NONE,        STEP_IDLE};
         STEP_R_NFOUND: w = '{ACT_EMIT_NFOUND, JMP_GOTO,     CND_NONE,        STEP_IDLE};
         default:       w = '{ACT_NOP,         JMP_GOTO,     CND_NONE,        STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* hw/rtl/word_table_sort_and_search_unit.sv */
// ----------------------------------------------------------------------------
// word_table_sort_and_search_unit: word table with sort and binary search
// microcoded sequencer over a dual-port word memory; append, selection
// sort ascending, and binary search of packed left-justified words
// ----------------------------------------------------------------------------
//  channel   ports                                  handshake
//  request   req_type, req_word                     start high, busy low
//  result    rsp_status, rsp_index                  rsp_strobe, one cycle
//
//  per beat, n = filled entries, p = probes: an unused request code
//    ends in a done status, a search makes p up to about log2(n) + 1
//    probes, and a sort of n below two writes nothing; the inner
//    compare loop of a sort reads each later entry from memory in turn;
//    after every item the sequencer returns to idle before it takes the
//    next start
//  reset clears the entry count and the sequencer; table contents are kept
//  a result is accepted in the cycle its strobe is high
// ----------------------------------------------------------------------------
module word_table_sort_and_search_unit #(
   parameter int CAPACITY   = 1024,
   parameter int WORD_CHARS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [wtss_pkg::REQ_W-1:0]    req_type,
   input  logic [wtss_pkg::WORD_W-1:0]   req_word,
   output logic                          rsp_strobe,
   output logic [wtss_pkg::STATUS_W-1:0] rsp_status,
   output logic [wtss_pkg::IDX_W-1:0]    rsp_index
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = CW + 1;
   localparam int IW = wtss_pkg::IDX_W;
   localparam int WW = wtss_pkg::WORD_W;
   localparam int SW = wtss_pkg::STEP_W;
   localparam logic [WW-1:0] CHAR_MASK = {WW{1'b1}} << (WW - 8 * WORD_CHARS);

   // sequencer
   wtss_pkg::step_type  pc_ff, pc_in;
   wtss_pkg::uword_type uw;
   logic                cond_hit;

   // datapath
   logic [WW-1:0]         key_ff, key_in;
   logic [wtss_pkg::REQ_W-1:0] req_ff, req_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         i_ff, i_in;
   logic [AW-1:0]         j_ff, j_in;
   logic [AW-1:0]         best_ff, best_in;
   logic [WW-1:0]         best_val_ff, best_val_in;
   logic [WW-1:0]         a_val_ff, a_val_in;
   logic signed [EW-1:0]  first_ff, first_in;
   logic signed [EW-1:0]  last_ff, last_in;
   logic [AW-1:0]         mid_ff, mid_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [wtss_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IW-1:0]         rsp_index_ff, rsp_index_in;

   // memory
   logic [WW-1:0] mem [CAPACITY];
   logic [WW-1:0] rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [WW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;

   // helpers
   logic [EW-1:0]      cnt_ext;
   logic [EW-1:0]      i_ext;
   logic [EW-1:0]      j_ext;
   logic [EW-1:0]      mid_ext;
   logic signed [EW:0] range_sum;
   logic [AW-1:0]      mid_calc;
   logic [AW-1:0]      pos;
   logic [IW+AW-1:0]   pos_wide;

   function automatic logic [SW-1:0] next_step(wtss_pkg::step_type s);
      return SW'(s) + SW'(1);
   endfunction

   assign cnt_ext   = {1'b0, cnt_ff};
   assign i_ext     = {{(EW-AW){1'b0}}, i_ff};
   assign j_ext     = {{(EW-AW){1'b0}}, j_ff};
   assign mid_ext   = {{(EW-AW){1'b0}}, mid_ff};
   assign range_sum = {first_ff[EW-1], first_ff} + {last_ff[EW-1], last_ff};
   assign mid_calc  = range_sum[AW:1];
   assign pos_wide  = {{IW{1'b0}}, pos};

   assign uw = wtss_pkg::ucode_rom(pc_ff);

   always_comb begin
      unique case (uw.cond)
         wtss_pkg::CND_FULL:        cond_hit = (cnt_ff == CW'(CAPACITY));
         wtss_pkg::CND_LT2:         cond_hit = (cnt_ff < CW'(2));
         wtss_pkg::CND_J_MORE:      cond_hit = ((j_ext + EW'(1)) < cnt_ext);
         wtss_pkg::CND_I_MORE:      cond_hit = ((i_ext + EW'(2)) < cnt_ext);
         wtss_pkg::CND_EMPTY_RANGE: cond_hit = (first_ff > last_ff);
         wtss_pkg::CND_KEY_NE:      cond_hit = (key_ff != rdata_ff);
         default:                   cond_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= wtss_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_comb begin
      pc_in = wtss_pkg::step_type'(next_step(pc_ff));
      unique case (uw.jump)
         wtss_pkg::JMP_NEXT: pc_in = wtss_pkg::step_type'(next_step(pc_ff));
         wtss_pkg::JMP_GOTO: pc_in = uw.target;
         wtss_pkg::JMP_IF: begin
            if (cond_hit) begin
               pc_in = uw.target;
            end
         end
         wtss_pkg::JMP_WAIT: pc_in = start ? uw.target : wtss_pkg::STEP_IDLE;
         wtss_pkg::JMP_DISPATCH: begin
            unique case (wtss_pkg::req_code_type'(req_ff))
               wtss_pkg::REQ_APPEND: pc_in = wtss_pkg::STEP_APP_CHK;
               wtss_pkg::REQ_SORT:   pc_in = wtss_pkg::STEP_S_INIT;
               wtss_pkg::REQ_SEARCH: pc_in = wtss_pkg::STEP_R_INIT;
               default:              pc_in = wtss_pkg::STEP_DONE;
            endcase
         end
         default: pc_in = wtss_pkg::STEP_IDLE;
      endcase
   end

   always_comb begin
      key_in        = key_ff;
      req_in        = req_ff;
      cnt_in        = cnt_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      best_in       = best_ff;
      best_val_in   = best_val_ff;
      a_val_in      = a_val_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      mid_in        = mid_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      mem_we        = 1'b0;
      mem_waddr     = i_ff;
      mem_wdata     = best_val_ff;
      mem_raddr     = i_ff;
      pos           = mid_ff;
      unique case (uw.action)
         wtss_pkg::ACT_NOP: begin
         end
         wtss_pkg::ACT_LATCH: begin
            if (start) begin
               key_in = req_word & CHAR_MASK;
               req_in = req_type;
            end
         end
         wtss_pkg::ACT_APPEND: begin
            mem_we        = 1'b1;
            mem_waddr     = cnt_ff[AW-1:0];
            mem_wdata     = key_ff;
            cnt_in        = cnt_ff + CW'(1);
            pos           = cnt_ff[AW-1:0];
            rsp_strobe_in = 1'b1;
            rsp_status_in = wtss_pkg::STS_DONE;
            rsp_index_in  = pos_wide[IW-1:0];
         end
         wtss_pkg::ACT_EMIT_FULL: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = wtss_pkg::STS_FULL;
            rsp_index_in  = '0;
         end
         wtss_pkg::ACT_EMIT_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = wtss_pkg::STS_DONE;
            rsp_index_in  = '0;
         end
         wtss_pkg::ACT_SORT_INIT: begin
            i_in = '0;
         end
         wtss_pkg::ACT_OUTER: begin
            mem_raddr = i_ff;
            best_in   = i_ff;
            j_in      = i_ff + AW'(1);
         end
         wtss_pkg::ACT_LOAD: begin
            best_val_in = rdata_ff;
            a_val_in    = rdata_ff;
         end
         wtss_pkg::ACT_READ_J: begin
            mem_raddr = j_ff;
         end
         wtss_pkg::ACT_CMP: begin
            if (rdata_ff < best_val_ff) begin
               best_in     = j_ff;
               best_val_in = rdata_ff;
            end
            j_in = j_ff + AW'(1);
         end
         wtss_pkg::ACT_WRITE_I: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = best_val_ff;
         end
         wtss_pkg::ACT_WRITE_BEST: begin
            mem_we    = 1'b1;
            mem_waddr = best_ff;
            mem_wdata = a_val_ff;
            i_in      = i_ff + AW'(1);
         end
         wtss_pkg::ACT_SRCH_INIT: begin
            first_in = '0;
            last_in  = $signed(cnt_ext) - EW'(1);
         end
         wtss_pkg::ACT_MID: begin
            mem_raddr = mid_calc;
            mid_in    = mid_calc;
         end
         wtss_pkg::ACT_PROBE: begin
            if (key_ff < rdata_ff) begin
               last_in = $signed(mid_ext) - EW'(1);
            end else begin
               first_in = $signed(mid_ext + EW'(1));
            end
         end
         wtss_pkg::ACT_EMIT_FOUND: begin
            pos           = mid_ff;
            rsp_strobe_in = 1'b1;
            rsp_status_in = wtss_pkg::STS_FOUND;
            rsp_index_in  = pos_wide[IW-1:0];
         end
         wtss_pkg::ACT_EMIT_NFOUND: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = wtss_pkg::STS_NOT_FOUND;
            rsp_index_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      req_ff        <= req_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      best_ff       <= best_in;
      best_val_ff   <= best_val_in;
      a_val_ff      <= a_val_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      mid_ff        <= mid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   assign busy       = (pc_ff != wtss_pkg::STEP_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;

   // every beat ends in exactly one strobe and a return to idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while sequencer still busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted beat did not start the sequencer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_full_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == wtss_pkg::STS_FULL)) |-> (rsp_index == '0))
      else $error("full status with nonzero index");

endmodule
